FILE: rtl/lpr_pkg.sv
`timescale 1ns / 1ps

package lpr_pkg;

  localparam int unsigned AddrBits = 32;
  localparam int unsigned LenW     = 6;
  localparam int unsigned IfW      = 4;
  localparam int unsigned TtlW     = 8;

  typedef enum logic [1:0] {
    StOk         = 2'd0,
    StNoRoute    = 2'd1,
    StTtlExpired = 2'd2,
    StFull       = 2'd3
  } status_e;

  typedef struct packed {
    logic [AddrBits-1:0] prefix;
    logic [LenW-1:0]     len;
  } route_key_t;

  typedef struct packed {
    logic                has_gw;
    logic [AddrBits-1:0] gw;
    logic [IfW-1:0]      iface;
  } route_action_t;

  typedef struct packed {
    route_key_t    key;
    route_action_t action;
  } route_entry_t;

  typedef struct packed {
    logic            found;
    logic [LenW-1:0] len;
  } best_t;

endpackage

FILE: rtl/ipv4_longest_prefix_router.sv
`timescale 1ns / 1ps
// IPv4 longest-prefix-match routing table.
// Input stream (s_axis): tuser selects the word kind, 0 adds a route and
// 1 routes one datagram; tdata carries the route and datagram fields.
// Output stream (m_axis): one word per input word; tuser is the status,
// tdata the chosen interface, next hop and decremented TTL.
// An add writes the route table at once and its answer moves into the
// output register from the Done state. A lookup reads the table one route
// per cycle through a single read port and one shared prefix compare unit,
// then passes through the Resolve and Done states; an empty table goes
// straight to Done. The input is not ready while a word is in work; it is
// ready again in the cycle after the result moves into the output register.
// The output register holds a finished word while the receiver stalls;
// the block may accept and work the next word meanwhile, and waits with
// its result until the register frees.
// Reset empties the table by clearing the route count; the table storage
// itself is not cleared and no entry is read before it is written.
module ipv4_longest_prefix_router #(
  parameter int unsigned MAX_ROUTES     = 64,
  parameter int unsigned NUM_INTERFACES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // [31:0] prefix, [37:32] prefix_len, [38] has_next_hop,
  // [70:39] next_hop_addr, [74:71] interface_index, [106:75] dst_addr,
  // [114:107] ttl_in, [119:115] zero
  input  logic [119:0]  s_axis_tdata,
  // [0] kind
  input  logic          s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [3:0] out_interface, [35:4] next_hop_out, [43:36] ttl_out, [47:44] zero
  output logic [47:0]   m_axis_tdata,
  // [1:0] status
  output logic [1:0]    m_axis_tuser
);
  import lpr_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_ROUTES + 1);
  localparam int unsigned IdxW = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_ROUTES);
  localparam logic [8:0] NumIf = 9'(NUM_INTERFACES);

  typedef enum logic [1:0] {
    Idle,
    Scan,
    Resolve,
    Done
  } state_e;

  logic                in_kind;
  logic [31:0]         in_prefix;
  logic [5:0]          in_len;
  logic                in_has_gw;
  logic [31:0]         in_gw;
  logic [3:0]          in_iface;
  logic [31:0]         in_dst;
  logic [7:0]          in_ttl;

  assign in_kind   = s_axis_tuser;
  assign in_prefix = s_axis_tdata[31:0];
  assign in_len    = s_axis_tdata[37:32];
  assign in_has_gw = s_axis_tdata[38];
  assign in_gw     = s_axis_tdata[70:39];
  assign in_iface  = s_axis_tdata[74:71];
  assign in_dst    = s_axis_tdata[106:75];
  assign in_ttl    = s_axis_tdata[114:107];

  state_e              state_q;
  logic [CntW-1:0]     count_q;
  logic [IdxW-1:0]     scan_idx_q;
  logic                issue_q;
  logic                rd_vld_q;
  route_entry_t        rd_entry_q;
  logic [31:0]         dst_q;
  logic [7:0]          ttl_q;
  best_t               best_q;
  route_action_t       best_act_q;
  status_e             res_status_q;
  logic [3:0]          res_if_q;
  logic [31:0]         res_hop_q;
  logic [7:0]          res_ttl_q;
  logic                m_valid_q;
  logic [47:0]         m_tdata_q;
  logic [1:0]          m_tuser_q;

  route_entry_t        mem [MAX_ROUTES];

  logic                accept;
  logic                table_full;
  logic                iface_ok;
  logic [5:0]          len_sat;
  logic                wr_en;
  route_entry_t        wr_entry;
  logic [CntW-1:0]     count_m1;
  logic [IdxW-1:0]     last_idx;
  logic                hit;
  logic                out_free;

  assign s_axis_tready = (state_q == Idle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign table_full    = (count_q == MaxCnt);
  assign iface_ok      = {5'd0, in_iface} < NumIf;
  assign len_sat       = (in_len > 6'(AddrBits)) ? 6'(AddrBits) : in_len;
  assign wr_en         = accept && !in_kind && !table_full && iface_ok;
  assign count_m1      = count_q - CntW'(1);
  assign last_idx      = count_m1[IdxW-1:0];
  assign out_free      = !m_valid_q || m_axis_tready;

  always_comb begin
    wr_entry.key.prefix    = in_prefix;
    wr_entry.key.len       = len_sat;
    wr_entry.action.has_gw = in_has_gw;
    wr_entry.action.gw     = in_gw;
    wr_entry.action.iface  = in_iface;
  end

  lpr_match_unit u_match (
    .dst_i  (dst_q),
    .key_i  (rd_entry_q.key),
    .best_i (best_q),
    .hit_o  (hit)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[IdxW-1:0]] <= wr_entry;
    end
    if (issue_q) begin
      rd_entry_q <= mem[scan_idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= Idle;
      count_q      <= '0;
      scan_idx_q   <= '0;
      issue_q      <= 1'b0;
      rd_vld_q     <= 1'b0;
      dst_q        <= '0;
      ttl_q        <= '0;
      best_q       <= '0;
      best_act_q   <= '0;
      res_if_q     <= '0;
      res_hop_q    <= '0;
      res_ttl_q    <= '0;
      m_valid_q    <= 1'b0;
      m_tdata_q    <= '0;
      m_tuser_q    <= '0;
      res_status_q <= StOk;
    end else begin
      if (m_valid_q && m_axis_tready && (state_q != Done)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        Idle: begin
          if (accept) begin
            dst_q      <= in_dst;
            ttl_q      <= in_ttl;
            best_q     <= '0;
            scan_idx_q <= '0;
            res_if_q   <= '0;
            res_hop_q  <= '0;
            res_ttl_q  <= '0;
            if (!in_kind) begin
              if (table_full) begin
                res_status_q <= StFull;
              end else if (!iface_ok) begin
                res_status_q <= StNoRoute;
              end else begin
                res_status_q <= StOk;
                count_q      <= count_q + CntW'(1);
              end
              state_q <= Done;
            end else if (count_q == '0) begin
              res_status_q <= StNoRoute;
              state_q      <= Done;
            end else begin
              issue_q <= 1'b1;
              state_q <= Scan;
            end
          end
        end
        Scan: begin
          rd_vld_q <= issue_q;
          if (issue_q) begin
            if (scan_idx_q == last_idx) begin
              issue_q <= 1'b0;
            end else begin
              scan_idx_q <= scan_idx_q + IdxW'(1);
            end
          end
          if (rd_vld_q && hit) begin
            best_q.found <= 1'b1;
            best_q.len   <= rd_entry_q.key.len;
            best_act_q   <= rd_entry_q.action;
          end
          if (rd_vld_q && !issue_q) begin
            state_q <= Resolve;
          end
        end
        Resolve: begin
          if (!best_q.found) begin
            res_status_q <= StNoRoute;
          end else if (ttl_q <= 8'd1) begin
            res_status_q <= StTtlExpired;
          end else begin
            res_status_q <= StOk;
            res_if_q     <= best_act_q.iface;
            res_hop_q    <= best_act_q.has_gw ? best_act_q.gw : dst_q;
            res_ttl_q    <= ttl_q - 8'd1;
          end
          state_q <= Done;
        end
        Done: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_tuser_q <= res_status_q;
            m_tdata_q <= {4'd0, res_ttl_q, res_hop_q, res_if_q};
            state_q   <= Idle;
          end
        end
        default: begin
          state_q <= Idle;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

endmodule

FILE: rtl/lpr_match_unit.sv
`timescale 1ns / 1ps

module lpr_match_unit (
  input  logic [31:0]        dst_i,
  input  lpr_pkg::route_key_t key_i,
  input  lpr_pkg::best_t      best_i,
  output logic               hit_o
);
  import lpr_pkg::*;

  logic [AddrBits-1:0] mask;
  logic                prefix_eq;
  logic                longer;

  assign mask      = ~({AddrBits{1'b1}} >> key_i.len);
  assign prefix_eq = ((dst_i ^ key_i.prefix) & mask) == '0;
  assign longer    = !best_i.found || (key_i.len > best_i.len);
  assign hit_o     = prefix_eq && longer;

endmodule
